@@ hw/rtl/sot_pkg.sv @@
// Shared constants, codes and control structs for the segment offset translator.
// No dependencies; every other file imports this package.
package sot_pkg;

    localparam int SEG_MAX = 16;
    localparam int IDX_W   = (SEG_MAX > 1) ? $clog2(SEG_MAX) : 1;
    localparam int CNT_W   = $clog2(SEG_MAX + 1);
    localparam int DATA_W  = 32;
    localparam int OP_W    = 2;
    localparam int MIDX_W  = 4;
    localparam int FOUND_W = 4;
    localparam int STAT_W  = 3;
    localparam int USED_W  = 5;
    localparam int CMP_W   = (CNT_W > MIDX_W + 1) ? CNT_W : MIDX_W + 1;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_MERGE  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_RANGE     = 3'd3,
        ST_BAD_MERGE = 3'd4
    } stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SRCH,
        S_CMP,
        S_OFFS,
        S_MRD,
        S_MWR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic  load_in;
        logic  res_set;
        stat_t res_code;
        logic  append_commit;
        logic  search_init;
        logic  search_step;
        logic  rd_prev;
        logic  offs_key;
        logic  offs_sub;
        logic  merge_init;
        logic  rd_next;
        logic  merge_write;
        logic  merge_finish;
        logic  clear_all;
        logic  load_out;
    } sot_cmd_t;

    typedef struct packed {
        op_t  op;
        logic len_zero;
        logic full;
        logic ovf;
        logic range_err;
        logic merge_bad;
        logic lo_lt_hi;
        logic lo_zero;
        logic mv_more;
        logic out_free;
    } sot_stat_t;

endpackage

@@ hw/rtl/sot_cmd_if.sv @@
// Request channel: valid/ready plus the operation fields.
// Depends on sot_pkg for field widths.
interface sot_cmd_if;
    import sot_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [DATA_W-1:0]   seg_length;
    logic [DATA_W-1:0]   lookup_key;
    logic [MIDX_W-1:0]   merge_index;

    modport source (output valid, op, seg_length, lookup_key, merge_index, input ready);
    modport sink   (input valid, op, seg_length, lookup_key, merge_index, output ready);
endinterface

@@ hw/rtl/sot_rsp_if.sv @@
// Result channel: valid/ready plus the result fields.
// Depends on sot_pkg for field widths.
interface sot_rsp_if;
    import sot_pkg::*;

    logic                valid;
    logic                ready;
    logic [FOUND_W-1:0]  segment_found;
    logic [DATA_W-1:0]   segment_offset;
    logic [STAT_W-1:0]   status;
    logic [USED_W-1:0]   segments_used;
    logic [DATA_W-1:0]   total_entries;

    modport source (output valid, segment_found, segment_offset, status, segments_used,
                    total_entries, input ready);
    modport sink   (input valid, segment_found, segment_offset, status, segments_used,
                    total_entries, output ready);
endinterface

@@ hw/rtl/sot_ctrl.sv @@
// Sequencing state machine: decodes each operation and steps search and merge.
// Depends on sot_pkg; drives sot_datapath through sot_cmd_t.
module sot_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  sot_pkg::sot_stat_t st,
    output sot_pkg::sot_cmd_t  cmd
);
    import sot_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (st.op)
                    OP_LOOKUP: state_next = st.range_err ? S_DONE : S_SRCH;
                    OP_MERGE:  state_next = st.merge_bad ? S_DONE : S_MRD;
                    default:   state_next = S_DONE;
                endcase
            end
            S_SRCH:
            begin
                if (st.lo_lt_hi)
                begin
                    state_next = S_CMP;
                end
                else if (st.lo_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_OFFS;
                end
            end
            S_CMP:  state_next = S_SRCH;
            S_OFFS: state_next = S_DONE;
            S_MRD:  state_next = st.mv_more ? S_MWR : S_DONE;
            S_MWR:  state_next = S_MRD;
            S_DONE:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.res_code = ST_OK;
        cmd_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready   = 1'b1;
                cmd.load_in = cmd_valid;
            end
            S_EXEC:
            begin
                case (st.op)
                    OP_APPEND:
                    begin
                        cmd.res_set = 1'b1;
                        if (st.len_zero)
                        begin
                            cmd.res_code = ST_OK;
                        end
                        else if (st.full)
                        begin
                            cmd.res_code = ST_FULL;
                        end
                        else if (st.ovf)
                        begin
                            cmd.res_code = ST_OVERFLOW;
                        end
                        else
                        begin
                            cmd.res_code      = ST_OK;
                            cmd.append_commit = 1'b1;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        if (st.range_err)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = ST_RANGE;
                        end
                        else
                        begin
                            cmd.search_init = 1'b1;
                        end
                    end
                    OP_MERGE:
                    begin
                        if (st.merge_bad)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = ST_BAD_MERGE;
                        end
                        else
                        begin
                            cmd.merge_init = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.res_set   = 1'b1;
                        cmd.res_code  = ST_OK;
                        cmd.clear_all = 1'b1;
                    end
                endcase
            end
            S_SRCH:
            begin
                if (!st.lo_lt_hi)
                begin
                    if (st.lo_zero)
                    begin
                        cmd.offs_key = 1'b1;
                    end
                    else
                    begin
                        cmd.rd_prev = 1'b1;
                    end
                end
            end
            S_CMP:  cmd.search_step = 1'b1;
            S_OFFS: cmd.offs_sub = 1'b1;
            S_MRD:
            begin
                if (st.mv_more)
                begin
                    cmd.rd_next = 1'b1;
                end
                else
                begin
                    cmd.merge_finish = 1'b1;
                    cmd.res_set      = 1'b1;
                    cmd.res_code     = ST_OK;
                end
            end
            S_MWR:  cmd.merge_write = 1'b1;
            S_DONE: cmd.load_out = st.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

@@ hw/rtl/sot_datapath.sv @@
// Boundary table memory, count/total state, search and merge pointers, result register.
// Depends on sot_pkg; commanded by sot_ctrl.
module sot_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sot_pkg::sot_cmd_t           cmd,
    output sot_pkg::sot_stat_t          st,
    input  logic [sot_pkg::OP_W-1:0]    op,
    input  logic [sot_pkg::DATA_W-1:0]  seg_length,
    input  logic [sot_pkg::DATA_W-1:0]  lookup_key,
    input  logic [sot_pkg::MIDX_W-1:0]  merge_index,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [sot_pkg::FOUND_W-1:0] segment_found,
    output logic [sot_pkg::DATA_W-1:0]  segment_offset,
    output logic [sot_pkg::STAT_W-1:0]  status,
    output logic [sot_pkg::USED_W-1:0]  segments_used,
    output logic [sot_pkg::DATA_W-1:0]  total_entries
);
    import sot_pkg::*;

    logic [DATA_W-1:0]  table_mem [SEG_MAX];
    logic [DATA_W-1:0]  rd_data_reg;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [DATA_W-1:0]  total_reg, total_next;
    logic               out_valid_reg, out_valid_next;

    op_t                op_reg, op_next;
    logic [DATA_W-1:0]  len_reg, len_next;
    logic [DATA_W-1:0]  key_reg, key_next;
    logic [MIDX_W-1:0]  midx_reg, midx_next;
    logic [IDX_W-1:0]   lo_reg, lo_next;
    logic [IDX_W-1:0]   hi_reg, hi_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic [FOUND_W-1:0] res_found_reg, res_found_next;
    logic [DATA_W-1:0]  res_offset_reg, res_offset_next;
    stat_t              res_status_reg, res_status_next;
    logic [FOUND_W-1:0] out_found_reg, out_found_next;
    logic [DATA_W-1:0]  out_offset_reg, out_offset_next;
    stat_t              out_status_reg, out_status_next;
    logic [USED_W-1:0]  out_used_reg, out_used_next;
    logic [DATA_W-1:0]  out_total_reg, out_total_next;

    logic [DATA_W:0]    sum;
    logic [IDX_W-1:0]   mid;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [DATA_W-1:0]  wr_data;
    logic [IDX_W-1:0]   rd_addr;

    assign sum = {1'b0, total_reg} + {1'b0, len_reg};
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        st.op        = op_reg;
        st.len_zero  = (len_reg == '0);
        st.full      = (count_reg >= CNT_W'(SEG_MAX));
        st.ovf       = sum[DATA_W];
        st.range_err = (key_reg >= total_reg) || (count_reg == '0);
        st.merge_bad = (CMP_W'(midx_reg) + CMP_W'(1)) >= CMP_W'(count_reg);
        st.lo_lt_hi  = (lo_reg < hi_reg);
        st.lo_zero   = (lo_reg == '0);
        st.mv_more   = (CNT_W'(ptr_reg) + CNT_W'(1)) < count_reg;
        st.out_free  = !out_valid_reg || rsp_ready;
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg;
        wr_data = rd_data_reg;
        if (cmd.append_commit)
        begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(count_reg);
            wr_data = sum[DATA_W-1:0];
        end
        else if (cmd.merge_write)
        begin
            wr_en = 1'b1;
        end

        if (cmd.rd_prev)
        begin
            rd_addr = lo_reg - IDX_W'(1);
        end
        else if (cmd.rd_next)
        begin
            rd_addr = ptr_reg + IDX_W'(1);
        end
        else
        begin
            rd_addr = mid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    always_comb
    begin
        count_next      = count_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        op_next         = op_reg;
        len_next        = len_reg;
        key_next        = key_reg;
        midx_next       = midx_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        ptr_next        = ptr_reg;
        res_found_next  = res_found_reg;
        res_offset_next = res_offset_reg;
        res_status_next = res_status_reg;
        out_found_next  = out_found_reg;
        out_offset_next = out_offset_reg;
        out_status_next = out_status_reg;
        out_used_next   = out_used_reg;
        out_total_next  = out_total_reg;

        if (cmd.load_in)
        begin
            op_next   = op_t'(op);
            len_next  = seg_length;
            key_next  = lookup_key;
            midx_next = merge_index;
        end
        if (cmd.res_set)
        begin
            res_found_next  = '0;
            res_offset_next = '0;
            res_status_next = cmd.res_code;
        end
        if (cmd.append_commit)
        begin
            total_next = sum[DATA_W-1:0];
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.clear_all)
        begin
            total_next = '0;
            count_next = '0;
        end
        if (cmd.search_init)
        begin
            lo_next = '0;
            hi_next = IDX_W'(count_reg - CNT_W'(1));
        end
        if (cmd.search_step)
        begin
            if (rd_data_reg > key_reg)
            begin
                hi_next = mid;
            end
            else
            begin
                lo_next = mid + IDX_W'(1);
            end
        end
        if (cmd.offs_key)
        begin
            res_found_next  = FOUND_W'(lo_reg);
            res_offset_next = key_reg;
            res_status_next = ST_OK;
        end
        if (cmd.offs_sub)
        begin
            res_found_next  = FOUND_W'(lo_reg);
            res_offset_next = key_reg - rd_data_reg;
            res_status_next = ST_OK;
        end
        if (cmd.merge_init)
        begin
            ptr_next = IDX_W'(midx_reg);
        end
        if (cmd.merge_write)
        begin
            ptr_next = ptr_reg + IDX_W'(1);
        end
        if (cmd.merge_finish)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.load_out)
        begin
            out_valid_next  = 1'b1;
            out_found_next  = res_found_reg;
            out_offset_next = res_offset_reg;
            out_status_next = res_status_reg;
            out_used_next   = USED_W'(count_reg);
            out_total_next  = total_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        len_reg        <= len_next;
        key_reg        <= key_next;
        midx_reg       <= midx_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        ptr_reg        <= ptr_next;
        res_found_reg  <= res_found_next;
        res_offset_reg <= res_offset_next;
        res_status_reg <= res_status_next;
        out_found_reg  <= out_found_next;
        out_offset_reg <= out_offset_next;
        out_status_reg <= out_status_next;
        out_used_reg   <= out_used_next;
        out_total_reg  <= out_total_next;
    end

    assign rsp_valid      = out_valid_reg;
    assign segment_found  = out_found_reg;
    assign segment_offset = out_offset_reg;
    assign status         = out_status_reg;
    assign segments_used  = out_used_reg;
    assign total_entries  = out_total_reg;

endmodule

@@ hw/rtl/segment_offset_translator.sv @@
// Top level of the segment offset translator: sot_ctrl plus sot_datapath.
// Depends on sot_pkg, sot_cmd_if and sot_rsp_if.
//
//  channel | dir | modport | payload
//  --------+-----+---------+---------------------------------------------------
//  cmd     | in  | sink    | op, seg_length, lookup_key, merge_index
//  rsp     | out | source  | segment_found, segment_offset, status,
//          |     |         | segments_used, total_entries
//
// One operation at a time; cmd.ready is high only between operations.
// Append, clear and rejected ops go from EXEC straight to DONE; lookup probes the
// table up to ceil(log2(segments)) times, with an OFFS step if not in segment 0;
// merge moves each entry above merge_index down by one, one read and one write each.
// The next cmd transfer can be taken in the same cycle that rsp.valid rises.
// rsp is a registered slot: a new cmd transfer is taken while it waits;
// a stalled rsp holds the next op in its final state. Table has no reset.
module segment_offset_translator (
    input  logic       clk,
    input  logic       rst_n,
    sot_cmd_if.sink    cmd,
    sot_rsp_if.source  rsp
);
    import sot_pkg::*;

    sot_cmd_t  ctrl_cmd;
    sot_stat_t dp_stat;

    sot_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .st        (dp_stat),
        .cmd       (ctrl_cmd)
    );

    sot_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (ctrl_cmd),
        .st             (dp_stat),
        .op             (cmd.op),
        .seg_length     (cmd.seg_length),
        .lookup_key     (cmd.lookup_key),
        .merge_index    (cmd.merge_index),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .segment_found  (rsp.segment_found),
        .segment_offset (rsp.segment_offset),
        .status         (rsp.status),
        .segments_used  (rsp.segments_used),
        .total_entries  (rsp.total_entries)
    );

endmodule

@@ hw/rtl/sot_checker.sv @@
// Port-level assertions for the segment offset translator, bound to the top.
// Depends on sot_pkg.
module sot_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cmd_valid,
    input logic                        cmd_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [sot_pkg::FOUND_W-1:0] segment_found,
    input logic [sot_pkg::DATA_W-1:0]  segment_offset,
    input logic [sot_pkg::STAT_W-1:0]  status,
    input logic [sot_pkg::USED_W-1:0]  segments_used,
    input logic [sot_pkg::DATA_W-1:0]  total_entries
);
    import sot_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(segment_offset)
            && $stable(status) && $stable(total_entries))
        else $error("rsp changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("cmd taken while an operation is in progress");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> segments_used <= USED_W'(SEG_MAX))
        else $error("segment count beyond table depth");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_OK |-> segment_found == '0 && segment_offset == '0)
        else $error("error result with nonzero lookup fields");

    a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && segments_used == '0 |-> total_entries == '0)
        else $error("empty table with nonzero total");

endmodule

bind segment_offset_translator sot_checker u_sot_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .segment_found  (rsp.segment_found),
    .segment_offset (rsp.segment_offset),
    .status         (rsp.status),
    .segments_used  (rsp.segments_used),
    .total_entries  (rsp.total_entries)
);

@@ tb/segment_offset_translator_tb.sv @@
// Self-checking testbench for segment_offset_translator: directed and random ops
// on the cmd channel, each rsp checked against a cycle-free table model.
// Depends on sot_pkg, sot_cmd_if, sot_rsp_if and the RTL of the block.
module segment_offset_translator_tb;
    import sot_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 250;
    localparam int TAIL_CYCLES = 60;

    typedef struct packed {
        logic [FOUND_W-1:0] found;
        logic [DATA_W-1:0]  offset;
        stat_t              status;
        logic [USED_W-1:0]  used;
        logic [DATA_W-1:0]  total;
    } rsp_t;

    class seg_table_sb;
        bit [DATA_W-1:0] seg_end [SEG_MAX];
        bit [USED_W-1:0] seg_cnt = '0;
        bit [DATA_W-1:0] total   = '0;
        rsp_t            pending_rsp [$];
        int              errors  = 0;

        function int pending();
            return pending_rsp.size();
        endfunction

        function void note_op(op_t kind, bit [DATA_W-1:0] len, bit [DATA_W-1:0] key,
                              bit [MIDX_W-1:0] midx);
            rsp_t       e;
            bit [4:0]   lo;
            bit [4:0]   hi;
            bit [4:0]   mid;
            int         i;
            e = '0;
            e.status = ST_OK;
            case (kind)
                OP_APPEND:
                    if (len != 0) begin
                        if (seg_cnt >= SEG_MAX)
                            e.status = ST_FULL;
                        else if ({1'b0, total} + {1'b0, len} > 33'h0_FFFF_FFFF)
                            e.status = ST_OVERFLOW;
                        else
                        begin
                            total = total + len;
                            seg_end[seg_cnt] = total;
                            seg_cnt++;
                        end
                    end
                OP_LOOKUP:
                    if (key >= total || seg_cnt == 0)
                        e.status = ST_RANGE;
                    else
                    begin
                        lo = 0;
                        hi = seg_cnt - 1;
                        while (lo < hi)
                        begin
                            mid = lo + (hi - lo) / 2;
                            if (seg_end[mid] > key)
                                hi = mid;
                            else
                                lo = mid + 1;
                        end
                        e.found  = lo[3:0];
                        e.offset = (lo == 0) ? key : key - seg_end[lo - 1];
                    end
                OP_MERGE:
                    if (int'(midx) + 1 >= int'(seg_cnt))
                        e.status = ST_BAD_MERGE;
                    else
                    begin
                        seg_end[midx] = seg_end[int'(midx) + 1];
                        for (i = int'(midx) + 1; i + 1 < int'(seg_cnt); i++)
                            seg_end[i] = seg_end[i + 1];
                        seg_cnt--;
                    end
                default:
                begin
                    seg_cnt = 0;
                    total   = 0;
                end
            endcase
            e.used  = seg_cnt;
            e.total = total;
            pending_rsp = {pending_rsp, e};
        endfunction

        function void check_rsp(rsp_t got);
            rsp_t e;
            if (pending_rsp.size() == 0)
            begin
                $error("rsp transfer with nothing expected");
                errors++;
                return;
            end
            e = pending_rsp.pop_front();
            if (got.found !== e.found)
            begin
                $error("segment_found: expected %0d, actual %0d", e.found, got.found);
                errors++;
            end
            if (got.offset !== e.offset)
            begin
                $error("segment_offset: expected %0d, actual %0d", e.offset, got.offset);
                errors++;
            end
            if (got.status !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, got.status);
                errors++;
            end
            if (got.used !== e.used)
            begin
                $error("segments_used: expected %0d, actual %0d", e.used, got.used);
                errors++;
            end
            if (got.total !== e.total)
            begin
                $error("total_entries: expected %0d, actual %0d", e.total, got.total);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sot_cmd_if cmd ();
    sot_rsp_if rsp ();

    segment_offset_translator i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    seg_table_sb sb = new;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit hold_req     = 1'b0;
    int ops_sent     = 0;
    int idle_cycles  = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // result side: random ready, plus a long hold-off on request
    initial
    begin
        rsp.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                rsp.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            rsp.ready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        rsp_t got;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.found  = rsp.segment_found;
                got.offset = rsp.segment_offset;
                got.status = stat_t'(rsp.status);
                got.used   = rsp.segments_used;
                got.total  = rsp.total_entries;
                sb.check_rsp(got);
            end
            if (cmd.valid && cmd.ready)
                sb.note_op(op_t'(cmd.op), cmd.seg_length, cmd.lookup_key, cmd.merge_index);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $error("no transfer for %0d cycles", IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_op(op_t kind, bit [DATA_W-1:0] len, bit [DATA_W-1:0] key,
                           bit [MIDX_W-1:0] midx);
        while ($urandom_range(99) < src_idle_pct)
            @(negedge clk);
        cmd.valid       = 1'b1;
        cmd.op          = kind;
        cmd.seg_length  = len;
        cmd.lookup_key  = key;
        cmd.merge_index = midx;
        do
            @(posedge clk);
        while (!cmd.ready);
        @(negedge clk);
        cmd.valid = 1'b0;
        ops_sent++;
    endtask

    task automatic wait_drain();
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic do_append(bit [DATA_W-1:0] len);
        send_op(OP_APPEND, len, $urandom, MIDX_W'($urandom_range(15)));
    endtask

    task automatic do_lookup(bit [DATA_W-1:0] key);
        send_op(OP_LOOKUP, $urandom, key, MIDX_W'($urandom_range(15)));
    endtask

    task automatic do_merge(bit [MIDX_W-1:0] midx);
        send_op(OP_MERGE, $urandom, $urandom, midx);
    endtask

    task automatic do_clear();
        send_op(OP_CLEAR, $urandom, $urandom, MIDX_W'($urandom_range(15)));
    endtask

    function automatic bit [DATA_W-1:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return $urandom_range(1, 2000);
        else if (r < 83)
            return '0;
        else if (r < 91)
            return $urandom;
        else if (r < 96)
            return ~sb.total;
        else
            return ~sb.total + 1;
    endfunction

    function automatic bit [DATA_W-1:0] pick_key();
        int              r;
        int              i;
        bit [DATA_W-1:0] b;
        r = $urandom_range(99);
        if (r < 45 && sb.total != 0)
            return $urandom % sb.total;
        if (r < 70 && sb.seg_cnt != 0)
        begin
            i = $urandom_range(0, sb.seg_cnt - 1);
            b = sb.seg_end[i];
            return $urandom_range(1) ? b : b - 1;
        end
        if (r < 80)
            return $urandom_range(1) ? sb.total : sb.total - 1;
        return $urandom;
    endfunction

    function automatic bit [MIDX_W-1:0] pick_midx();
        if (sb.seg_cnt >= 2 && $urandom_range(3) != 0)
            return MIDX_W'($urandom_range(0, sb.seg_cnt - 2));
        return MIDX_W'($urandom_range(15));
    endfunction

    task automatic run_random(int n);
        int target;
        int k;
        int r;
        target = ops_sent + n;
        while (ops_sent < target)
        begin
            if ($urandom_range(9) == 0)
                send_op(op_t'($urandom_range(3)), $urandom, $urandom,
                        MIDX_W'($urandom_range(15)));
            else
            begin
                if ($urandom_range(1))
                    do_clear();
                repeat ($urandom_range(1, 18)) do_append(pick_len());
                k = $urandom_range(4, 16);
                repeat (k)
                begin
                    r = $urandom_range(99);
                    if (r < 50)
                        do_lookup(pick_key());
                    else if (r < 72)
                        do_merge(pick_midx());
                    else
                        do_append(pick_len());
                end
            end
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cmd.valid       = 1'b0;
        cmd.op          = OP_APPEND;
        cmd.seg_length  = '0;
        cmd.lookup_key  = '0;
        cmd.merge_index = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty table, zero length, overflow, full table, merge edges
        do_lookup('0);
        do_merge('0);
        do_append('0);
        do_append(32'hFFFF_FFF0);
        do_append(32'h0000_0010);
        do_lookup(32'hFFFF_FFEF);
        do_lookup(32'hFFFF_FFF0);
        do_merge('0);
        repeat (15) do_append(32'd1);
        do_append(32'd1);
        do_lookup(32'hFFFF_FFFE);
        do_lookup(32'hFFFF_FFF0);
        do_merge(4'd15);
        do_merge(4'd14);
        do_merge('0);
        do_clear();
        wait_drain();

        src_idle_pct = 21;
        snk_idle_pct = 63;
        run_random(165);
        wait_drain();

        src_idle_pct = 63;
        snk_idle_pct = 21;
        run_random(165);
        wait_drain();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(55);
        hold_req = 1'b1;
        run_random(12);
        wait_drain();
        run_random(80);
        wait_drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
